// ----- rtl/rf3_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf3_pkg
// Shared constants and types of the 3x3 rank-order filter.
// ----------------------------------------------------------------------------
package rf3_pkg;

    localparam int PIX_W     = 8;
    localparam int MAX_LINE  = 1024;
    localparam int ROW_LIMIT = 1024;
    localparam int COL_W     = $clog2(MAX_LINE);
    localparam int ROW_W     = $clog2(ROW_LIMIT);
    localparam int WD_W      = COL_W + 1;
    localparam int HT_W      = ROW_W + 1;
    localparam int COORD_W   = 10;

    localparam int NWIN      = 9;
    localparam int NHIST     = 6;
    localparam int RANK_W    = 4;
    localparam int RANK_MAX  = 8;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd2;

    localparam logic [RANK_W-1:0] RANK_RESET   = 4'd4;
    localparam logic [WD_W-1:0]   WIDTH_RESET  = WD_W'(640);
    localparam logic [HT_W-1:0]   HEIGHT_RESET = HT_W'(480);
    localparam int                DIM_MIN      = 3;

    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef struct packed {
        logic [NWIN-1:0][PIX_W-1:0] win;
        logic [COORD_W-1:0]         col;
        logic [COORD_W-1:0]         row;
        logic                       last;
    } t_item;

endpackage

// ----- rtl/rf3_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf3_front
// Raster position tracking, line store and window assembly; pushes full
// windows into the work queue.
// ----------------------------------------------------------------------------
module rf3_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [rf3_pkg::PIX_W-1:0]           i_pixel_value,
    input  logic                                i_frame_start,
    input  logic [rf3_pkg::WD_W-1:0]            i_width,
    input  logic [rf3_pkg::HT_W-1:0]            i_height,
    input  logic [rf3_pkg::Q_CNT_W-1:0]         i_q_count,
    output logic                                o_push,
    output rf3_pkg::t_item                      o_item
);

    logic [2*rf3_pkg::PIX_W-1:0] mem [rf3_pkg::MAX_LINE];
    logic [2*rf3_pkg::PIX_W-1:0] r_rd;

    logic [rf3_pkg::COL_W-1:0] r_col, n_col;
    logic [rf3_pkg::ROW_W-1:0] r_row, n_row;
    logic [rf3_pkg::NHIST-1:0][rf3_pkg::PIX_W-1:0] r_win;

    logic                      r_s1_valid;
    logic [rf3_pkg::PIX_W-1:0] r_s1_p;
    logic [rf3_pkg::COL_W-1:0] r_s1_col;
    logic [rf3_pkg::ROW_W-1:0] r_s1_row;
    logic                      r_s1_has;
    logic                      r_s1_last;
    logic                      r_byp;
    logic [rf3_pkg::PIX_W-1:0] r_byp_top;
    logic [rf3_pkg::PIX_W-1:0] r_byp_mid;

    logic                      accept;
    logic [rf3_pkg::WD_W-1:0]  c0, c1, cn;
    logic [rf3_pkg::HT_W-1:0]  r0, r1, r2, rn;
    logic                      has_win;
    logic                      is_last;
    logic [rf3_pkg::COL_W-1:0] rd_addr;
    logic [rf3_pkg::PIX_W-1:0] top, mid;

    assign o_in_stall = (i_q_count + rf3_pkg::Q_CNT_W'(r_s1_valid))
                        >= rf3_pkg::Q_CNT_W'(rf3_pkg::Q_DEPTH);
    assign accept = i_in_valid && !o_in_stall;

    always_comb begin
        c0 = i_frame_start ? '0 : {1'b0, r_col};
        r0 = i_frame_start ? '0 : {1'b0, r_row};
        if (c0 >= i_width) begin
            c1 = '0;
            r1 = r0 + 1'b1;
        end else begin
            c1 = c0;
            r1 = r0;
        end
        r2 = (r1 >= i_height) ? '0 : r1;
        has_win = (c1 >= rf3_pkg::WD_W'(2)) && (r2 >= rf3_pkg::HT_W'(2));
        is_last = (c1 == i_width - 1'b1) && (r2 == i_height - 1'b1);
        cn = c1 + 1'b1;
        rn = r2 + 1'b1;
        if (cn >= i_width) begin
            n_col = '0;
            n_row = (rn >= i_height) ? '0 : rn[rf3_pkg::ROW_W-1:0];
        end else begin
            n_col = cn[rf3_pkg::COL_W-1:0];
            n_row = r2[rf3_pkg::ROW_W-1:0];
        end
        rd_addr = c1[rf3_pkg::COL_W-1:0];
    end

    assign top = r_byp ? r_byp_top : r_rd[2*rf3_pkg::PIX_W-1:rf3_pkg::PIX_W];
    assign mid = r_byp ? r_byp_mid : r_rd[rf3_pkg::PIX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (r_s1_valid) begin
            mem[r_s1_col] <= {mid, r_s1_p};
        end
        r_rd <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
            r_win      <= '0;
        end else begin
            r_s1_valid <= accept;
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
            if (r_s1_valid) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_s1_p;
            end
        end
    end

    // same column back to back: memory write not yet visible to the read
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_p    <= i_pixel_value;
            r_s1_col  <= rd_addr;
            r_s1_row  <= r2[rf3_pkg::ROW_W-1:0];
            r_s1_has  <= has_win;
            r_s1_last <= is_last;
            r_byp     <= r_s1_valid && (r_s1_col == rd_addr);
            r_byp_top <= mid;
            r_byp_mid <= r_s1_p;
        end
    end

    always_comb begin
        for (int k = 0; k < rf3_pkg::NHIST; k++) begin
            o_item.win[k] = r_win[k];
        end
        o_item.win[6] = top;
        o_item.win[7] = mid;
        o_item.win[8] = r_s1_p;
        o_item.col    = rf3_pkg::COORD_W'(r_s1_col - 1'b1);
        o_item.row    = rf3_pkg::COORD_W'(r_s1_row - 1'b1);
        o_item.last   = r_s1_last;
    end

    assign o_push = r_s1_valid && r_s1_has;

    a_byp_same_col: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && r_byp) |-> ($past(r_s1_valid) && $past(r_s1_col) == r_s1_col))
        else $error("bypass taken without a same-column predecessor");

endmodule

// ----- rtl/rf3_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf3_fifo
// Short window queue between the front and the sorting back end.
// ----------------------------------------------------------------------------
module rf3_fifo (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  rf3_pkg::t_item              i_item,
    input  logic                        i_pop,
    output rf3_pkg::t_item              o_head,
    output logic [rf3_pkg::Q_CNT_W-1:0] o_count
);

    rf3_pkg::t_item              r_mem [rf3_pkg::Q_DEPTH];
    logic [rf3_pkg::Q_PTR_W-1:0] r_head;
    logic [rf3_pkg::Q_PTR_W-1:0] r_tail;
    logic [rf3_pkg::Q_CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_tail] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_tail  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_tail <= r_tail + 1'b1;
            end
            if (i_pop) begin
                r_head <= r_head + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_head  = r_mem[r_head];
    assign o_count = r_count;

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count != rf3_pkg::Q_CNT_W'(rf3_pkg::Q_DEPTH)))
        else $error("window queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("window queue underflow");

endmodule

// ----- rtl/rf3_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rf3_back
// Rank selection over a nine-value window: pairwise compare stage, then
// position count and select into the output register.
// ----------------------------------------------------------------------------
module rf3_back (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [rf3_pkg::Q_CNT_W-1:0]  i_q_count,
    input  rf3_pkg::t_item               i_head,
    output logic                         o_pop,
    input  logic [rf3_pkg::RANK_W-1:0]   i_rank,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [rf3_pkg::PIX_W-1:0]    o_ranked_value,
    output logic [rf3_pkg::COORD_W-1:0]  o_center_col,
    output logic [rf3_pkg::COORD_W-1:0]  o_center_row,
    output logic                         o_frame_last
);

    logic                                         r_a_valid;
    rf3_pkg::t_item                               r_a_item;
    logic [rf3_pkg::NWIN-1:0][rf3_pkg::NWIN-1:0]  r_a_less;

    logic                         r_o_valid;
    logic [rf3_pkg::PIX_W-1:0]    r_o_value;
    logic [rf3_pkg::COORD_W-1:0]  r_o_col;
    logic [rf3_pkg::COORD_W-1:0]  r_o_row;
    logic                         r_o_last;

    logic                                         adv_o;
    logic                                         adv_a;
    logic [rf3_pkg::NWIN-1:0][rf3_pkg::NWIN-1:0]  less;
    logic [rf3_pkg::NWIN-1:0]                     sel;
    logic [rf3_pkg::PIX_W-1:0]                    value;

    assign adv_o = !r_o_valid || !i_out_stall;
    assign adv_a = !r_a_valid || adv_o;
    assign o_pop = (i_q_count != '0) && adv_a;

    // stable order: ties broken by window slot
    always_comb begin
        for (int i = 0; i < rf3_pkg::NWIN; i++) begin
            for (int j = 0; j < rf3_pkg::NWIN; j++) begin
                less[i][j] = (i_head.win[j] < i_head.win[i]) ||
                             ((i_head.win[j] == i_head.win[i]) && (j < i));
            end
        end
    end

    always_comb begin
        value = '0;
        for (int i = 0; i < rf3_pkg::NWIN; i++) begin
            sel[i] = (rf3_pkg::RANK_W'($countones(r_a_less[i])) == i_rank);
            value  = value | (sel[i] ? r_a_item.win[i] : '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (adv_a) begin
                r_a_valid <= o_pop;
            end
            if (adv_o) begin
                r_o_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_a_item <= i_head;
            r_a_less <= less;
        end
        if (adv_o && r_a_valid) begin
            r_o_value <= value;
            r_o_col   <= r_a_item.col;
            r_o_row   <= r_a_item.row;
            r_o_last  <= r_a_item.last;
        end
    end

    assign o_out_valid    = r_o_valid;
    assign o_ranked_value = r_o_value;
    assign o_center_col   = r_o_col;
    assign o_center_row   = r_o_row;
    assign o_frame_last   = r_o_last;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_a_valid |-> $onehot(sel))
        else $error("rank select does not pick exactly one window value");

endmodule

// ----- rtl/rank_filter_3x3_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_filter_3x3_unit
// 3x3 rank-order filter over a raster grey pixel stream.
//
//   channel  | direction | handshake                 | beat
//   ---------+-----------+---------------------------+----------------------
//   in       | input     | i_in_valid / o_in_stall   | pixel, frame start
//   out      | output    | o_out_valid / i_out_stall | ranked value, center
//   cfg      | input     | i_cfg_valid / o_cfg_ready | register index, data
//
// One pixel per cycle while o_in_stall is low; a window passes the line store
// stage, queue, compare stage and output register before o_out_valid rises.
// Input stalls while the queued windows plus the beat in the line store
// stage reach four; the sort pipeline stalls only on i_out_stall.
// Reset is synchronous; the line store is not cleared.
// ----------------------------------------------------------------------------
module rank_filter_3x3_unit (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [rf3_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                             i_frame_start,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [rf3_pkg::PIX_W-1:0]        o_ranked_value,
    output logic [rf3_pkg::COORD_W-1:0]      o_center_col,
    output logic [rf3_pkg::COORD_W-1:0]      o_center_row,
    output logic                             o_frame_last,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [rf3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rf3_pkg::CFG_W-1:0]        i_cfg_data
);

    logic [rf3_pkg::RANK_W-1:0] r_rank, n_rank;
    logic [rf3_pkg::WD_W-1:0]   r_width, n_width;
    logic [rf3_pkg::HT_W-1:0]   r_height, n_height;

    logic                        push;
    logic                        pop;
    rf3_pkg::t_item              push_item;
    rf3_pkg::t_item              head_item;
    logic [rf3_pkg::Q_CNT_W-1:0] q_count;

    assign o_cfg_ready = 1'b1;

    // registers hold clamped values
    always_comb begin
        if (i_cfg_data[rf3_pkg::RANK_W-1:0] > rf3_pkg::RANK_W'(rf3_pkg::RANK_MAX)) begin
            n_rank = rf3_pkg::RANK_W'(rf3_pkg::RANK_MAX);
        end else begin
            n_rank = i_cfg_data[rf3_pkg::RANK_W-1:0];
        end
        if (i_cfg_data < rf3_pkg::CFG_W'(rf3_pkg::DIM_MIN)) begin
            n_width = rf3_pkg::WD_W'(rf3_pkg::DIM_MIN);
        end else if (i_cfg_data > rf3_pkg::CFG_W'(rf3_pkg::MAX_LINE)) begin
            n_width = rf3_pkg::WD_W'(rf3_pkg::MAX_LINE);
        end else begin
            n_width = rf3_pkg::WD_W'(i_cfg_data);
        end
        if (i_cfg_data < rf3_pkg::CFG_W'(rf3_pkg::DIM_MIN)) begin
            n_height = rf3_pkg::HT_W'(rf3_pkg::DIM_MIN);
        end else if (i_cfg_data > rf3_pkg::CFG_W'(rf3_pkg::ROW_LIMIT)) begin
            n_height = rf3_pkg::HT_W'(rf3_pkg::ROW_LIMIT);
        end else begin
            n_height = rf3_pkg::HT_W'(i_cfg_data);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank   <= rf3_pkg::RANK_RESET;
            r_width  <= rf3_pkg::WIDTH_RESET;
            r_height <= rf3_pkg::HEIGHT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                rf3_pkg::CFG_RANK:   r_rank   <= n_rank;
                rf3_pkg::CFG_WIDTH:  r_width  <= n_width;
                rf3_pkg::CFG_HEIGHT: r_height <= n_height;
                default:             r_rank   <= r_rank;
            endcase
        end
    end

    rf3_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_value  (i_pixel_value),
        .i_frame_start  (i_frame_start),
        .i_width        (r_width),
        .i_height       (r_height),
        .i_q_count      (q_count),
        .o_push         (push),
        .o_item         (push_item)
    );

    rf3_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (push_item),
        .i_pop    (pop),
        .o_head   (head_item),
        .o_count  (q_count)
    );

    rf3_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_count       (q_count),
        .i_head          (head_item),
        .o_pop           (pop),
        .i_rank          (r_rank),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_ranked_value  (o_ranked_value),
        .o_center_col    (o_center_col),
        .o_center_row    (o_center_row),
        .o_frame_last    (o_frame_last)
    );

endmodule

// ----- tb/rank_filter_3x3_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_filter_3x3_checker
// Watches the pixel, result and register channels of rank_filter_3x3_unit,
// runs its own 3x3 rank filter over every accepted pixel beat, and compares
// each accepted result beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module rank_filter_3x3_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    input  logic                             i_in_stall,
    input  logic [rf3_pkg::PIX_W-1:0]        i_pixel_value,
    input  logic                             i_frame_start,
    input  logic                             i_out_valid,
    input  logic                             i_out_stall,
    input  logic [rf3_pkg::PIX_W-1:0]        i_ranked_value,
    input  logic [rf3_pkg::COORD_W-1:0]      i_center_col,
    input  logic [rf3_pkg::COORD_W-1:0]      i_center_row,
    input  logic                             i_frame_last,
    input  logic                             i_cfg_valid,
    input  logic                             i_cfg_ready,
    input  logic [rf3_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [rf3_pkg::CFG_W-1:0]        i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_result_count
);
    import rf3_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [PIX_W-1:0]   value;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
        logic               last;
    } t_ranked_pix;

    t_ranked_pix       pending_results[$];
    logic [PIX_W-1:0]  upper_line [MAX_LINE];
    logic [PIX_W-1:0]  middle_line [MAX_LINE];
    logic [PIX_W-1:0]  col_hist [NHIST];
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [RANK_W-1:0] rank_sel;
    logic [CFG_W-1:0]  width_cfg;
    logic [CFG_W-1:0]  height_cfg;
    int                fail_count = 0;
    int                result_count = 0;

    function automatic int unsigned dim_clamp(input logic [CFG_W-1:0] v, input int unsigned hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return 32'(v);
    endfunction

    function automatic logic [PIX_W-1:0] rank_of_window(
        input logic [NWIN-1:0][PIX_W-1:0] win,
        input logic [RANK_W-1:0]          rank
    );
        logic [PIX_W-1:0] s [NWIN];
        logic [PIX_W-1:0] t;
        int               pick;
        for (int i = 0; i < NWIN; i++) s[i] = win[i];
        for (int i = 0; i < NWIN - 1; i++) begin
            for (int j = 0; j < NWIN - 1 - i; j++) begin
                if (s[j] > s[j+1]) begin
                    t      = s[j];
                    s[j]   = s[j+1];
                    s[j+1] = t;
                end
            end
        end
        pick = (rank > RANK_MAX) ? RANK_MAX : int'(rank);
        return s[pick];
    endfunction

    task automatic filter_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int unsigned                w;
        int unsigned                h;
        int unsigned                c;
        int unsigned                r;
        logic [PIX_W-1:0]           top;
        logic [PIX_W-1:0]           mid;
        logic [NWIN-1:0][PIX_W-1:0] win;
        t_ranked_pix                res;
        w = dim_clamp(width_cfg, MAX_LINE);
        h = dim_clamp(height_cfg, ROW_LIMIT);
        c = col_pos;
        r = row_pos;
        if (fs) begin
            c = 0;
            r = 0;
        end
        // geometry may have shrunk under the current position
        if (c >= w) begin
            c = 0;
            r = r + 1;
        end
        if (r >= h) r = 0;

        top = upper_line[c[COL_W-1:0]];
        mid = middle_line[c[COL_W-1:0]];
        upper_line[c[COL_W-1:0]]  = mid;
        middle_line[c[COL_W-1:0]] = pix;

        if (c >= 2 && r >= 2) begin
            for (int k = 0; k < NHIST; k++) win[k] = col_hist[k];
            win[6]    = top;
            win[7]    = mid;
            win[8]    = pix;
            res.value = rank_of_window(win, rank_sel);
            res.col   = COORD_W'(c - 1);
            res.row   = COORD_W'(r - 1);
            res.last  = (c == w - 1) && (r == h - 1);
            pending_results = {pending_results, res};
        end

        col_hist[0] = col_hist[3];
        col_hist[1] = col_hist[4];
        col_hist[2] = col_hist[5];
        col_hist[3] = top;
        col_hist[4] = mid;
        col_hist[5] = pix;

        c = c + 1;
        if (c >= w) begin
            c = 0;
            r = r + 1;
            if (r >= h) r = 0;
        end
        col_pos = c;
        row_pos = r;
    endtask

    task automatic check_result(input t_ranked_pix got);
        t_ranked_pix want;
        if (pending_results.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("[%0t] unexpected result beat: val=%0d col=%0d row=%0d last=%0b",
                         $time, got.value, got.col, got.row, got.last);
            return;
        end
        want = pending_results.pop_front();
        if (got.value !== want.value || got.col !== want.col ||
            got.row !== want.row || got.last !== want.last) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
                $display("[%0t] result mismatch: exp val=%0d col=%0d row=%0d last=%0b, %s",
                         $time, want.value, want.col, want.row, want.last,
                         $sformatf("got val=%0d col=%0d row=%0d last=%0b",
                                   got.value, got.col, got.row, got.last));
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rank_sel   = RANK_RESET;
            width_cfg  = CFG_W'(WIDTH_RESET);
            height_cfg = CFG_W'(HEIGHT_RESET);
            for (int k = 0; k < MAX_LINE; k++) begin
                upper_line[k]  = '0;
                middle_line[k] = '0;
            end
            for (int k = 0; k < NHIST; k++) col_hist[k] = '0;
            col_pos = 0;
            row_pos = 0;
            pending_results.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_RANK:   rank_sel   = i_cfg_data[RANK_W-1:0];
                    CFG_WIDTH:  width_cfg  = i_cfg_data;
                    CFG_HEIGHT: height_cfg = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                filter_pixel(i_pixel_value, i_frame_start);
            if (i_out_valid && !i_out_stall) begin
                result_count++;
                check_result({i_ranked_value, i_center_col, i_center_row, i_frame_last});
            end
        end
        o_fail_count   <= fail_count;
        o_pending      <= pending_results.size();
        o_result_count <= result_count;
    end

endmodule

// ----- tb/rank_filter_3x3_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rank_filter_3x3_unit_tb
// Drives raster pixel streams through rank_filter_3x3_unit under many rank
// and geometry settings: a directed opening (minimum frames, rank extremes,
// clamped register values, frame wrap, shrinking geometry, mid-frame frame
// start), then random frames with random idling on both channels and a
// closing stretch without idling. A separate checker predicts and compares
// every result beat.
// ----------------------------------------------------------------------------
module rank_filter_3x3_unit_tb;
    import rf3_pkg::*;

    localparam int                   CLK_PERIOD    = 12;
    localparam int                   RESET_CYCLES  = 9;
    localparam int                   CYCLE_LIMIT   = 200_000;
    localparam int                   RANDOM_PIXELS = 1150;
    localparam int                   DRAIN_CYCLES  = 12;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;

    typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} t_idle_mode;
    typedef enum int {PIX_ANY, PIX_EXTREME, PIX_NARROW} t_pix_style;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_pixel_value;
    logic                 i_frame_start;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [PIX_W-1:0]     o_ranked_value;
    logic [COORD_W-1:0]   o_center_col;
    logic [COORD_W-1:0]   o_center_row;
    logic                 o_frame_last;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_data;

    int                   fail_count;
    int                   pending;
    int                   result_count;

    t_idle_mode           in_idle  = IDLE_NONE;
    t_idle_mode           out_idle = IDLE_NONE;
    logic                 draining = 1'b1;
    int                   out_burst = 0;
    int                   cycle_count = 0;
    int                   pixels_sent = 0;
    int                   reg_writes = 0;
    int                   settings_used = 0;
    int unsigned          cur_width = 0;

    rank_filter_3x3_unit dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_pixel_value  (i_pixel_value),
        .i_frame_start  (i_frame_start),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_ranked_value (o_ranked_value),
        .o_center_col   (o_center_col),
        .o_center_row   (o_center_row),
        .o_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data)
    );

    rank_filter_3x3_checker chk (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_pixel_value  (i_pixel_value),
        .i_frame_start  (i_frame_start),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_ranked_value (o_ranked_value),
        .i_center_col   (o_center_col),
        .i_center_row   (o_center_row),
        .i_frame_last   (o_frame_last),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_result_count (result_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // result-side back-pressure, applied in bursts of random length
    always @(posedge i_clk) begin
        if (!i_rst_n || draining || out_idle == IDLE_NONE) begin
            i_out_stall <= 1'b0;
            out_burst   <= 0;
        end else if (out_burst > 0) begin
            i_out_stall <= 1'b1;
            out_burst   <= out_burst - 1;
        end else if ($urandom_range(0, 99) < ((out_idle == IDLE_HEAVY) ? 20 : 4)) begin
            i_out_stall <= 1'b1;
            out_burst   <= $urandom_range(0, 13);
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    function automatic int unsigned dim_clamp(input int unsigned v, input int unsigned hi);
        if (v < DIM_MIN) return DIM_MIN;
        if (v > hi) return hi;
        return v;
    endfunction

    function automatic int idle_gap(input t_idle_mode m);
        if (m == IDLE_NONE) return 0;
        if ($urandom_range(0, 99) < ((m == IDLE_HEAVY) ? 20 : 4)) return $urandom_range(1, 14);
        return 0;
    endfunction

    function automatic logic [PIX_W-1:0] next_pixel(input t_pix_style style);
        case (style)
            PIX_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            PIX_NARROW:  return PIX_W'($urandom_range(120, 127));
            default:     return PIX_W'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] pix, input logic fs);
        int gap;
        gap = idle_gap(in_idle);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_pixel_value <= pix;
        i_frame_start <= fs;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pixels_sent++;
    endtask

    // fw/fh are the dimensions in effect; frame starts fall on frame
    // boundaries at random, or anywhere when noisy
    task automatic send_raster(input int n, input int unsigned fw, input int unsigned fh,
                               input logic fs_first, input t_pix_style style,
                               input logic noisy);
        int unsigned pos;
        logic        fs;
        pos = 0;
        for (int k = 0; k < n; k++) begin
            fs = 1'b0;
            if (k == 0) begin
                fs = fs_first;
            end else if (pos == 0) begin
                fs = 1'($urandom_range(0, 1));
            end else if (noisy && $urandom_range(0, 99) < 2) begin
                fs  = 1'b1;
                pos = 0;
            end
            push_pixel(next_pixel(style), fs);
            pos = (pos + 1) % (fw * fh);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_idle();
        draining <= 1'b1;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        reg_writes++;
    endtask

    task automatic program_filter(input int unsigned rank, input int unsigned w,
                                  input int unsigned h);
        write_reg(CFG_RANK, CFG_W'(rank));
        write_reg(CFG_WIDTH, CFG_W'(w));
        write_reg(CFG_HEIGHT, CFG_W'(h));
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic start_phase(input t_idle_mode in_m, input t_idle_mode out_m);
        in_idle  = in_m;
        out_idle <= out_m;
        draining <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin
        int unsigned rank;
        int unsigned wv;
        int unsigned hv;
        int unsigned ew;
        int unsigned eh;
        int          n;
        int          room;
        int          rand_base;
        logic        fs_first;

        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_pixel_value = '0;
        i_frame_start = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = CFG_RANK;
        i_cfg_data    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // smallest frame, minimum rank; spare index must be ignored
        write_reg(CFG_SPARE, CFG_W'($urandom_range(0, 2047)));
        program_filter(0, 3, 3);
        cur_width = 3;
        start_phase(IDLE_HEAVY, IDLE_HEAVY);
        send_raster(9, 3, 3, 1'b1, PIX_EXTREME, 1'b0);

        // maximum rank, frame wraps without a frame start
        wait_idle();
        program_filter(8, 3, 3);
        start_phase(IDLE_LIGHT, IDLE_HEAVY);
        send_raster(9, 3, 3, 1'b0, PIX_EXTREME, 1'b0);

        // rank saturates, width and height below minimum
        wait_idle();
        write_reg(CFG_RANK, 11'h7FF);
        write_reg(CFG_WIDTH, 11'd0);
        write_reg(CFG_HEIGHT, 11'd1);
        i_cfg_valid <= 1'b0;
        settings_used++;
        start_phase(IDLE_NONE, IDLE_NONE);
        send_raster(9, 3, 3, 1'b0, PIX_ANY, 1'b0);

        // width shrinks under the current column
        wait_idle();
        program_filter(4, 6, 5);
        cur_width = 6;
        start_phase(IDLE_HEAVY, IDLE_LIGHT);
        send_raster(11, 6, 5, 1'b1, PIX_ANY, 1'b0);
        wait_idle();
        program_filter(2, 4, 5);
        cur_width = 4;
        start_phase(IDLE_LIGHT, IDLE_LIGHT);
        send_raster(12, 4, 5, 1'b0, PIX_ANY, 1'b0);

        // height shrinks under the current row
        wait_idle();
        program_filter(6, 4, 6);
        start_phase(IDLE_LIGHT, IDLE_HEAVY);
        send_raster(18, 4, 6, 1'b1, PIX_NARROW, 1'b0);
        wait_idle();
        write_reg(CFG_HEIGHT, 11'd3);
        i_cfg_valid <= 1'b0;
        settings_used++;
        start_phase(IDLE_HEAVY, IDLE_HEAVY);
        send_raster(10, 4, 3, 1'b0, PIX_ANY, 1'b0);

        // frame start in the middle of a row
        wait_idle();
        program_filter(4, 7, 4);
        cur_width = 7;
        start_phase(IDLE_LIGHT, IDLE_LIGHT);
        send_raster(10, 7, 4, 1'b1, PIX_ANY, 1'b0);
        send_raster(28, 7, 4, 1'b1, PIX_ANY, 1'b0);

        rand_base = pixels_sent;
        while (pixels_sent - rand_base < RANDOM_PIXELS) begin
            wait_idle();
            rank = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            case ($urandom_range(0, 19))
                0:       wv = $urandom_range(0, 2);
                1, 2:    wv = $urandom_range(17, 40);
                default: wv = $urandom_range(3, 16);
            endcase
            hv = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
            if ($urandom_range(0, 3) == 0 && cur_width <= 40) begin
                // keep the geometry, change the rank only (upper data bits unused)
                write_reg(CFG_RANK, CFG_W'(($urandom_range(0, 127) << RANK_W) | rank));
                i_cfg_valid <= 1'b0;
                settings_used++;
                ew = cur_width;
                eh = dim_clamp(hv, ROW_LIMIT);
                fs_first = 1'b1;
            end else begin
                program_filter(rank, wv, hv);
                ew = dim_clamp(wv, MAX_LINE);
                eh = dim_clamp(hv, ROW_LIMIT);
                // a growing width must restart the frame so every line store
                // entry read belongs to the current frame
                fs_first = (ew > cur_width) || ($urandom_range(0, 3) != 0);
                cur_width = ew;
            end
            n = (ew * eh > 100) ? ew * eh : $urandom_range(1, 3) * ew * eh;
            if ($urandom_range(0, 1)) n = n + $urandom_range(0, ew * eh - 1);
            room = RANDOM_PIXELS - (pixels_sent - rand_base);
            if (n > room) n = room;
            start_phase(t_idle_mode'($urandom_range(0, 2)), t_idle_mode'($urandom_range(0, 2)));
            send_raster(n, ew, eh, fs_first, t_pix_style'($urandom_range(0, 2)),
                        $urandom_range(0, 3) == 0);
        end

        // closing stretch without idling
        wait_idle();
        program_filter(4, 9, 6);
        start_phase(IDLE_NONE, IDLE_NONE);
        send_raster(2 * 9 * 6, 9, 6, 1'b1, PIX_ANY, 1'b0);
        wait_idle();

        $display("Sent %0d pixel beats over %0d register settings (%0d writes), %0d results checked.",
                 pixels_sent, settings_used, reg_writes, result_count);
        $display("Ranks 0 to 15, clamped and small geometries, wrap, restart and shrink cases.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("%0d result beats failed", fail_count);
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
